@@ src/slip_frame_decoder_core_assert.svh @@
// Assertion macros shared by the SLIP decoder modules
`ifndef SLIP_FRAME_DECODER_CORE_ASSERT_SVH
`define SLIP_FRAME_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfd check failed");

// next-cycle implication, checked outside reset
`define SFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfd check failed");

`endif

@@ src/sfd_pkg.sv @@
// Types and constants for the SLIP frame decoder
`timescale 1ns / 1ps

package sfd_pkg;

    localparam logic [7:0] SLIP_END     = 8'hC0;
    localparam logic [7:0] SLIP_ESC     = 8'hDB;
    localparam logic [7:0] SLIP_ESC_END = 8'hDC;
    localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

    localparam logic [7:0] FRAME_LIMIT_RESET = 8'd32;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_RECV   = 2'd1,
        MODE_ESCAPE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_END   = 2'd1,
        KIND_TRUNC = 2'd2,
        KIND_ABORT = 2'd3
    } kind_t;

    typedef struct packed {
        logic       line_error;
        logic [7:0] line_byte;
    } item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] frame_length;
        logic [7:0] byte_index;
        logic [7:0] data_byte;
    } res_t;

endpackage

@@ src/slip_frame_decoder_core.sv @@
// Top level of the SLIP frame decoder
`timescale 1ns / 1ps

// SLIP receive decoder.
// Input stream: one line word per transfer, tdata = line_byte, tuser = line_error.
// Output stream: at most one result word per input word; tuser = kind
// (data, frame end, truncated, aborted), tdata = data_byte, byte_index,
// frame_length from the lowest bit up.
// A frame opens on 0xC0, closes on the next 0xC0; 0xDB escapes the next word.
// Decoded words past frame_limit truncate the frame; a line error aborts it.
// frame_limit is written through cfg_we / cfg_data; the user must write it only
// while the block is idle, as the block itself does not enforce this. Throughput:
// one input word per cycle unless a stall drops s_axis_tready. A taken word waits
// in the input register while the combinational decode fills the result register.
// Reset clears both valid flags, sets the decoder idle with a zero count and
// frame_limit to 32.
// When the receiver stalls, a word in the input register that yields no result
// still moves on; one that yields a result waits there and s_axis_tready drops
// until the held result is taken.
module slip_frame_decoder_core
    import sfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] line_byte
    input  logic        s_axis_tuser,   // [0] line_error
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [15:8] byte_index, [23:16] frame_length
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);

`include "slip_frame_decoder_core_assert.svh"

    logic [7:0] frame_limit_reg;
    logic       in_valid_reg;
    logic       in_valid_next;
    item_t      in_item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    res_t       out_res_reg;
    logic       advance;
    logic       res_valid;
    res_t       res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_limit_reg <= FRAME_LIMIT_RESET;
        else if (cfg_we)
            frame_limit_reg <= cfg_data;
    end

    sfd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (in_item_reg),
        .frame_limit (frame_limit_reg),
        .res_valid   (res_valid),
        .res         (res)
    );

    // a word with no result may leave even while the output is stalled
    assign advance       = in_valid_reg && (!res_valid || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && res_valid)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.line_byte  <= s_axis_tdata;
            in_item_reg.line_error <= s_axis_tuser;
        end
        if (advance && res_valid)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.frame_length, out_res_reg.byte_index,
                            out_res_reg.data_byte};
    assign m_axis_tuser  = out_res_reg.kind;

    `SFD_ASSERT_NEXT(a_input_held, in_valid_reg && !advance,
        in_valid_reg && $stable(in_item_reg))
    `SFD_ASSERT_NEXT(a_result_loaded, advance && res_valid,
        out_valid_reg && out_res_reg == $past(res))

endmodule

@@ src/sfd_decode.sv @@
// SLIP decode state machine: mode and byte count, one word per step
`timescale 1ns / 1ps

module sfd_decode
    import sfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  item_t      item,
    input  logic [7:0] frame_limit,
    output logic       res_valid,
    output res_t       res
);

`include "slip_frame_decoder_core_assert.svh"

    mode_t      mode_reg;
    mode_t      mode_next;
    logic [7:0] byte_count_reg;
    logic [7:0] byte_count_next;
    logic [7:0] esc_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            byte_count_reg <= 8'd0;
        end
        else if (step)
        begin
            mode_reg       <= mode_next;
            byte_count_reg <= byte_count_next;
        end
    end

    always_comb
    begin
        priority if (item.line_byte == SLIP_ESC_END)
            esc_value = SLIP_END;
        else if (item.line_byte == SLIP_ESC_ESC)
            esc_value = SLIP_ESC;
        else
            esc_value = item.line_byte;
    end

    always_comb
    begin
        mode_next       = mode_reg;
        byte_count_next = byte_count_reg;
        res_valid       = 1'b0;
        res             = '0;

        if (item.line_error)
        begin
            mode_next = MODE_IDLE;
            if (mode_reg == MODE_RECV || mode_reg == MODE_ESCAPE)
            begin
                res_valid        = 1'b1;
                res.kind         = KIND_ABORT;
                res.frame_length = byte_count_reg;
            end
        end
        else
        begin
            unique case (mode_reg)
                MODE_RECV, MODE_ESCAPE:
                begin
                    if (mode_reg == MODE_RECV && item.line_byte == SLIP_END)
                    begin
                        mode_next        = MODE_IDLE;
                        res_valid        = 1'b1;
                        res.kind         = KIND_END;
                        res.frame_length = byte_count_reg;
                    end
                    else if (mode_reg == MODE_RECV && item.line_byte == SLIP_ESC)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else if (byte_count_reg < frame_limit)
                    begin
                        // store the decoded word
                        mode_next       = MODE_RECV;
                        byte_count_next = byte_count_reg + 8'd1;
                        res_valid       = 1'b1;
                        res.kind        = KIND_DATA;
                        res.data_byte   = (mode_reg == MODE_ESCAPE) ? esc_value
                                                                     : item.line_byte;
                        res.byte_index  = byte_count_reg;
                    end
                    else
                    begin
                        // frame full: drop the word and close as truncated
                        mode_next        = MODE_IDLE;
                        res_valid        = 1'b1;
                        res.kind         = KIND_TRUNC;
                        res.frame_length = byte_count_reg;
                    end
                end
                default:
                begin
                    // idle, and the unused mode code
                    if (item.line_byte == SLIP_END)
                    begin
                        mode_next       = MODE_RECV;
                        byte_count_next = 8'd0;
                    end
                    else
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
            endcase
        end
    end

    `SFD_ASSERT_NEXT(a_data_counts, step && res_valid && res.kind == KIND_DATA,
        byte_count_reg == $past(byte_count_reg) + 8'd1 && mode_reg == MODE_RECV)
    `SFD_ASSERT_NEXT(a_error_idles, step && item.line_error, mode_reg == MODE_IDLE)
    `SFD_ASSERT_NOW(a_index_in_limit, res_valid && res.kind == KIND_DATA,
        res.byte_index < frame_limit)

endmodule

@@ tb/slip_frame_decoder_core_test.sv @@
// Testbench for the SLIP frame decoder core: random framed traffic checked word by word
`timescale 1ns / 1ps

module slip_frame_decoder_core_test
    import sfd_pkg::*;
();

    // Tracks decoder mode, byte count and limit; holds the result words still due
    class frame_tracker;
        mode_t       mode;
        logic [7:0]  count;
        logic [7:0]  limit;
        res_t        due[$];
        int unsigned failures;

        function new();
            mode     = MODE_IDLE;
            count    = 8'd0;
            limit    = FRAME_LIMIT_RESET;
            failures = 0;
        endfunction

        function void set_limit(logic [7:0] value);
            limit = value;
        endfunction

        // decoded byte goes in, or the frame is cut short when full
        function res_t store_byte(logic [7:0] value);
            res_t r;
            r = '0;
            if (count < limit)
            begin
                r.kind       = KIND_DATA;
                r.data_byte  = value;
                r.byte_index = count;
                count        = count + 8'd1;
                mode         = MODE_RECV;
            end
            else
            begin
                r.kind         = KIND_TRUNC;
                r.frame_length = count;
                mode           = MODE_IDLE;
            end
            return r;
        endfunction

        function void take_word(logic [7:0] b, logic err);
            res_t r;
            logic [7:0] v;
            r = '0;
            if (err)
            begin
                if (mode == MODE_RECV || mode == MODE_ESCAPE)
                begin
                    r.kind         = KIND_ABORT;
                    r.frame_length = count;
                    due.push_back(r);
                end
                mode = MODE_IDLE;
            end
            else if (mode == MODE_RECV)
            begin
                if (b == SLIP_END)
                begin
                    r.kind         = KIND_END;
                    r.frame_length = count;
                    mode           = MODE_IDLE;
                    due.push_back(r);
                end
                else if (b == SLIP_ESC)
                    mode = MODE_ESCAPE;
                else
                    due.push_back(store_byte(b));
            end
            else if (mode == MODE_ESCAPE)
            begin
                v = b;
                if (b == SLIP_ESC_END)
                    v = SLIP_END;
                else if (b == SLIP_ESC_ESC)
                    v = SLIP_ESC;
                due.push_back(store_byte(v));
            end
            else if (b == SLIP_END)
            begin
                mode  = MODE_RECV;
                count = 8'd0;
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_word(logic [23:0] data, logic [1:0] user);
            res_t want;
            if (due.size() == 0)
            begin
                $error("result word with nothing due: kind %0d data 0x%06h", user, data);
                failures++;
                return;
            end
            want = due.pop_front();
            compare_field("kind", want.kind, user);
            compare_field("data_byte", want.data_byte, data[7:0]);
            compare_field("byte_index", want.byte_index, data[15:8]);
            compare_field("frame_length", want.frame_length, data[23:16]);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    frame_tracker tracker = new();
    bit           sender_gapless;
    bit           sink_gapless;
    bit           hold_request;
    int           words_sent;

    slip_frame_decoder_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #2ms;
        $display("slip_frame_decoder_core: mismatch");
        $finish;
    end

    function automatic int unsigned draw_gap(bit gapless);
        if (gapless || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // result side: random stalls, plus one long hold-off when asked
    initial
    begin
        int unsigned gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (250) @(negedge clk);
            end
            gap = draw_gap(sink_gapless);
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            tracker.check_word(m_axis_tdata, m_axis_tuser);
        end
    end

    task automatic send_word(input logic [7:0] b, input logic err);
        int unsigned gap;
        gap = draw_gap(sender_gapless);
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= err;
        do
            @(posedge clk);
        while (!s_axis_tready);
        tracker.take_word(b, err);
        words_sent++;
    endtask

    // stop sending, wait for every due word, then let the pipeline drain
    task automatic settle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (tracker.due.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        tracker.set_limit(value);
    endtask

    // one frame of n decoded bytes; sometimes odd escapes or a line error
    task automatic send_frame(input int unsigned n);
        logic [7:0]  b;
        int unsigned pick;
        send_word(SLIP_END, 1'b0);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 2)
            begin
                send_word(8'($urandom), 1'b1);
                return;
            end
            b    = 8'($urandom);
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                // escape in front of any byte, special or not
                send_word(SLIP_ESC, 1'b0);
                if ($urandom_range(0, 9) == 0)
                begin
                    send_word(8'($urandom), 1'b1);
                    return;
                end
                send_word(b, 1'b0);
            end
            else if (b == SLIP_END)
            begin
                send_word(SLIP_ESC, 1'b0);
                send_word(SLIP_ESC_END, 1'b0);
            end
            else if (b == SLIP_ESC)
            begin
                send_word(SLIP_ESC, 1'b0);
                send_word(SLIP_ESC_ESC, 1'b0);
            end
            else
                send_word(b, 1'b0);
        end
        send_word(SLIP_END, 1'b0);
    endtask

    // line noise between frames; noise words are not counted
    task automatic send_noise();
        int unsigned n;
        n = $urandom_range(1, 4);
        repeat (n)
            send_word(8'($urandom), ($urandom_range(0, 3) == 0));
        words_sent -= n;
    endtask

    initial
    begin
        logic [7:0]  limits[10];
        int unsigned budget;
        int unsigned len;
        int unsigned cap;

        cfg_we        = 1'b0;
        cfg_data      = 8'd0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tuser  = 1'b0;
        hold_request  = 1'b0;
        words_sent    = 0;
        limits        = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd0, 8'd17, 8'd128, 8'd5, 8'd255, 8'd32};
        limits[5]     = 8'($urandom_range(1, 255));

        @(posedge rst_n);

        // reset limit of 32 in force here
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b1);
        send_word(SLIP_END, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(SLIP_ESC, 1'b0);
        send_word(SLIP_ESC_END, 1'b0);
        send_word(SLIP_ESC, 1'b0);
        send_word(SLIP_ESC_ESC, 1'b0);
        send_word(SLIP_ESC, 1'b0);
        send_word(8'h41, 1'b0);
        send_word(SLIP_ESC, 1'b0);
        send_word(SLIP_END, 1'b0);
        send_word(SLIP_END, 1'b0);
        send_word(SLIP_END, 1'b0);
        send_word(SLIP_END, 1'b0);
        send_word(SLIP_END, 1'b0);
        send_word(8'h12, 1'b0);
        send_word(SLIP_END, 1'b1);
        send_word(SLIP_END, 1'b0);
        send_word(SLIP_ESC, 1'b0);
        send_word(8'h7E, 1'b1);
        send_word(8'h33, 1'b0);
        settle();

        foreach (limits[p])
        begin
            write_limit(limits[p]);
            sender_gapless = (p % 3 == 1);
            sink_gapless   = (p % 4 == 2);
            if (p == 3)
            begin
                sender_gapless = 1'b1;
                hold_request   = 1'b1;
            end
            if (limits[p] == 8'd1)
            begin
                send_word(SLIP_END, 1'b0);
                send_word(8'h5A, 1'b0);
                send_word(8'hA5, 1'b0);
                send_word(8'h77, 1'b0);
            end
            if (limits[p] == 8'd255)
                send_frame(256);
            budget = words_sent + 130;
            while (words_sent < budget)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                begin
                    cap = limits[p] + 2;
                    if (cap > 40 && $urandom_range(0, 7) != 0)
                        cap = 40;
                    len = $urandom_range(0, cap);
                    send_frame(len);
                end
            end
            settle();
        end

        if (tracker.failures == 0 && tracker.due.size() == 0)
            $display("slip_frame_decoder_core: match");
        else
            $display("slip_frame_decoder_core: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/sfd_pkg.sv
src/sfd_decode.sv
src/slip_frame_decoder_core.sv
tb/slip_frame_decoder_core_test.sv
